// ===== src/pphs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Priority heap scheduler package
// Shared types, widths and result codes of the heap scheduler.
// ----------------------------------------------------------------------------
package pphs_pkg;

  localparam int unsigned HeapDepth = 16;
  localparam int unsigned IdxW      = $clog2(HeapDepth);
  localparam int unsigned CntW      = $clog2(HeapDepth + 1);

  localparam logic OpArrive = 1'b0;
  localparam logic OpTick   = 1'b1;

  localparam logic [2:0] KindAccepted = 3'd0;
  localparam logic [2:0] KindRejected = 3'd1;
  localparam logic [2:0] KindIdle     = 3'd2;
  localparam logic [2:0] KindRan      = 3'd3;
  localparam logic [2:0] KindFinished = 3'd4;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] work_left;
    logic [15:0] burst;
    logic [31:0] arrived;
    logic [31:0] resp;
    logic        resp_ok;
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

endpackage
`default_nettype wire

// ===== src/preemptive_priority_heap_scheduler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Preemptive priority heap scheduler
// Binary min-heap scheduler: arrive pushes a job, tick runs the root job for
// one time unit and reports its times when it finishes.
//
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  opcode, job_id, job_priority, job_burst
// out      output     out_valid/out_ready kind, ran_id, times
//
// Each heap step reads one entry through the registered heap RAM port, so a
// sift-up level passes StUpRd, StUpWt and StUpCmp and a sift-down level
// passes StDnRdL, StDnRdR, StDnWtR and StDnCmp. The block returns to StIdle
// after the result is taken and only then takes the next item.
// Reset clears the count and the clock; the heap RAM needs no clearing.
// While a result waits on out_ready the block holds and takes no new item.
// ----------------------------------------------------------------------------
module preemptive_priority_heap_scheduler_core
  import pphs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode_i,
  input  wire logic [7:0]  job_id_i,
  input  wire logic [7:0]  job_priority_i,
  input  wire logic [15:0] job_burst_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind_o,
  output logic [7:0]       ran_id_o,
  output logic [31:0]      tick_time_o,
  output logic [31:0]      response_time_o,
  output logic [31:0]      waiting_time_o,
  output logic [31:0]      turnaround_time_o
);

  typedef enum logic [3:0] {
    StIdle, StRootRd, StRootWt, StLastRd, StLastWt,
    StDnRdL, StDnRdR, StDnWtR, StDnCmp,
    StUpRd, StUpWt, StUpCmp, StOut
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [31:0]       now_q;
  job_t              cur_q;
  job_t              run_q;
  job_t              lft_q;
  logic [IdxW-1:0]   k_q;
  logic [IdxW-1:0]   raddr;
  logic              we;
  logic [IdxW-1:0]   waddr;
  job_t              wdata;
  logic [JobW-1:0]   rdata;
  job_t              rd_job;
  job_t              root_w;
  job_t              requeue_w;
  logic [IdxW+1:0]   lc_w;
  logic [IdxW+1:0]   rc_w;
  logic [IdxW+1:0]   cnt_w;
  logic [IdxW-1:0]   par_w;
  logic [31:0]       done_w;
  logic [7:0]        best_prio_w;
  logic              l_ok_w;
  logic              r_ok_w;
  logic              dn_swap_w;
  logic              up_swap_w;

  pphs_ram #(.Width(JobW), .Depth(HeapDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_job   = job_t'(rdata);
  assign lc_w     = {1'b0, k_q, 1'b1};
  assign rc_w     = lc_w + 1'b1;
  assign cnt_w    = (IdxW + 2)'(count_q);
  assign par_w    = IdxW'((k_q - 1'b1) >> 1);
  assign done_w   = now_q + 32'd1;
  assign in_ready = (state_q == StIdle);

  assign l_ok_w      = (lc_w < cnt_w) && (lft_q.prio < cur_q.prio);
  assign best_prio_w = l_ok_w ? lft_q.prio : cur_q.prio;
  assign r_ok_w      = (rc_w < cnt_w) && (rd_job.prio < best_prio_w);
  assign dn_swap_w   = l_ok_w || r_ok_w;
  assign up_swap_w   = (k_q != '0) && (lft_q.prio > cur_q.prio);

  always_comb begin
    root_w = rd_job;
    if (!rd_job.resp_ok) begin
      root_w.resp    = now_q - 32'd1 - rd_job.arrived;
      root_w.resp_ok = 1'b1;
    end
  end

  always_comb begin
    requeue_w           = run_q;
    requeue_w.work_left = run_q.work_left - 16'd1;
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = k_q;
    wdata = cur_q;
    unique case (state_q)
      StRootRd: raddr = '0;
      StLastRd: raddr = IdxW'(count_q);
      StDnRdL:  raddr = lc_w[IdxW-1:0];
      StDnRdR:  raddr = rc_w[IdxW-1:0];
      StDnWtR:  raddr = rc_w[IdxW-1:0];
      StUpRd:   raddr = par_w;
      StDnCmp: begin
        we = 1'b1;
        if (r_ok_w) begin
          wdata = rd_job;
        end else if (l_ok_w) begin
          wdata = lft_q;
        end
      end
      StUpCmp: begin
        we = 1'b1;
        if (up_swap_w) begin
          wdata = lft_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= StIdle;
      count_q           <= '0;
      now_q             <= '0;
      out_valid         <= 1'b0;
      k_q               <= '0;
      cur_q             <= '0;
      run_q             <= '0;
      lft_q             <= '0;
      kind_o            <= KindIdle;
      ran_id_o          <= '0;
      tick_time_o       <= '0;
      response_time_o   <= '0;
      waiting_time_o    <= '0;
      turnaround_time_o <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid) begin
            tick_time_o       <= now_q;
            ran_id_o          <= '0;
            response_time_o   <= '0;
            waiting_time_o    <= '0;
            turnaround_time_o <= '0;
            if (opcode_i == OpArrive) begin
              if (count_q == CntW'(HeapDepth)) begin
                kind_o  <= KindRejected;
                state_q <= StOut;
              end else begin
                kind_o  <= KindAccepted;
                cur_q   <= '{id: job_id_i, prio: job_priority_i,
                             work_left: job_burst_i, burst: job_burst_i,
                             arrived: now_q, resp: 32'd0, resp_ok: 1'b0};
                k_q     <= IdxW'(count_q);
                count_q <= count_q + 1'b1;
                state_q <= (count_q == '0) ? StUpCmp : StUpRd;
              end
            end else begin
              now_q <= done_w;
              if (count_q == '0) begin
                kind_o  <= KindIdle;
                state_q <= StOut;
              end else begin
                count_q <= count_q - 1'b1;
                state_q <= StRootRd;
              end
            end
          end
        end
        StRootRd: state_q <= StRootWt;
        StRootWt: begin
          run_q   <= root_w;
          k_q     <= '0;
          state_q <= (count_q == '0) ? StDnCmp : StLastRd;
        end
        StLastRd: state_q <= StLastWt;
        StLastWt: begin
          cur_q   <= rd_job;
          k_q     <= '0;
          state_q <= StDnRdL;
        end
        StDnRdL: begin
          if (lc_w >= cnt_w) begin
            state_q <= StDnCmp;
          end else begin
            state_q <= StDnRdR;
          end
        end
        StDnRdR: begin
          lft_q   <= rd_job;
          state_q <= StDnWtR;
        end
        StDnWtR: state_q <= StDnCmp;
        StDnCmp: begin
          if (dn_swap_w) begin
            k_q     <= r_ok_w ? rc_w[IdxW-1:0] : lc_w[IdxW-1:0];
            state_q <= StDnRdL;
          end else begin
            ran_id_o <= run_q.id;
            if (run_q.work_left > 16'd1) begin
              cur_q   <= requeue_w;
              k_q     <= IdxW'(count_q);
              kind_o  <= KindRan;
              count_q <= count_q + 1'b1;
              state_q <= (count_q == '0) ? StUpCmp : StUpRd;
            end else begin
              kind_o            <= KindFinished;
              response_time_o   <= run_q.resp;
              turnaround_time_o <= now_q - run_q.arrived;
              waiting_time_o    <= now_q - run_q.arrived - {16'd0, run_q.burst};
              state_q           <= StOut;
            end
          end
        end
        StUpRd: state_q <= StUpWt;
        StUpWt: begin
          lft_q   <= rd_job;
          state_q <= StUpCmp;
        end
        StUpCmp: begin
          if (up_swap_w) begin
            k_q     <= par_w;
            state_q <= (par_w == '0) ? StUpCmp : StUpRd;
          end else begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/pphs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module pphs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
